// ===== design/i2a_pkg.sv =====
// Shared constants, control and status types, and character mapping for the radix converter.
package i2a_pkg;

  localparam int DEFAULT_WORD_WIDTH = 32;
  localparam int NUMBER_W = 32;
  localparam int RADIX_W = 6;
  localparam int DIGIT_W = 6;
  localparam int CHAR_W = 7;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;
  localparam logic [DIGIT_W-1:0] DIGIT_NINE = 6'd9;
  localparam logic [DIGIT_W-1:0] DIGIT_TEN = 6'd10;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 7'd57;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 7'd97;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 7'd122;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'd45;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture a new number, radix and sign
    logic step;       // one restoring division step
    logic sign_load;  // place '-' in the output register
    logic read;       // pop one digit from the digit store
    logic char_load;  // place the popped digit in the output register
  } i2a_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic neg;            // the value is shown with a sign
    logic step_last;      // this step finishes the current digit
    logic quo_zero_next;  // quotient after this step is zero
    logic count_zero;     // no digits left in the store
  } i2a_status_t;

  function automatic logic [CHAR_W-1:0] digit_to_char(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d > DIGIT_NINE) begin
      c = CHAR_LOWER_A + CHAR_W'(d - DIGIT_TEN);
    end else begin
      c = CHAR_ZERO + CHAR_W'(d);
    end
    return c;
  endfunction

endpackage

// ===== design/integer_to_ascii_radix.sv =====
// Top level of the integer to ASCII radix converter.
//
// Input channel (in_valid/in_ready): one transaction carries number, radix and
// signed_mode. The radix saturates to 2..36. In signed mode with radix 10 a
// negative word prints as '-' followed by its magnitude; otherwise the word is
// printed as an unsigned pattern of WORD_WIDTH bits.
// Output channel (out_valid/out_ready): one transaction per character, most
// significant digit first, with last_char set on the final one.
// Throughput: one number is handled at a time. Loading comes first, then each
// digit is worked out bit by bit over the whole word by the bit-serial
// restoring divider. Each character then passes through stack read, register
// and show, plus any stall, and the sign through register and show.
// Reset: rst returns the controller to idle; in_ready rises, out_valid drops.
// Stall: while out_ready is low the current character and its last mark hold
// in the output register and no further work is done.
module integer_to_ascii_radix import i2a_pkg::*; #(
  parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [NUMBER_W-1:0] number,
  input  logic [RADIX_W-1:0]  radix,
  input  logic                signed_mode,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [CHAR_W-1:0]   ascii_char,
  output logic                last_char
);

  i2a_cmd_t    cmd;
  i2a_status_t status;

  // Sequence the conversion.
  i2a_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Divide, stack the digits and hold the character being offered.
  i2a_datapath #(
    .WORD_WIDTH (WORD_WIDTH)
  ) u_datapath (
    .clk         (clk),
    .number      (number),
    .radix       (radix),
    .signed_mode (signed_mode),
    .cmd         (cmd),
    .status      (status),
    .ascii_char  (ascii_char),
    .last_char   (last_char)
  );

endmodule

// ===== design/i2a_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
module i2a_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/i2a_datapath.sv =====
// Datapath: operand capture, bit-serial restoring divider, digit stack and output register.
module i2a_datapath import i2a_pkg::*; #(
  parameter int WORD_WIDTH = DEFAULT_WORD_WIDTH
) (
  input  logic                clk,
  input  logic [NUMBER_W-1:0] number,
  input  logic [RADIX_W-1:0]  radix,
  input  logic                signed_mode,
  input  i2a_cmd_t            cmd,
  output i2a_status_t         status,
  output logic [CHAR_W-1:0]   ascii_char,
  output logic                last_char
);

  localparam int SW = $clog2(WORD_WIDTH);
  localparam int AW = $clog2(WORD_WIDTH);
  localparam int CW = $clog2(WORD_WIDTH + 1);

  logic [WORD_WIDTH-1:0]   val;
  logic [DIGIT_W-1:0]      rem;
  logic [RADIX_W-1:0]      radix_r;
  logic                    neg;
  logic [SW-1:0]           step;
  logic [CW-1:0]           count;
  logic [CW-1:0]           count_dec;

  logic [WORD_WIDTH+NUMBER_W-1:0] num_wide;
  logic [WORD_WIDTH-1:0]   num_w;
  logic [RADIX_W-1:0]      radix_sat;
  logic                    neg_in;
  logic [DIGIT_W:0]        rem_sh;
  logic                    q_bit;
  logic [DIGIT_W-1:0]      rem_new;
  logic [WORD_WIDTH-1:0]   quo_new;
  logic                    step_last;
  logic                    digit_we;
  logic [DIGIT_W-1:0]      rd_digit;

  // Reduce the input to the word width, zero extending when the word is wider.
  assign num_wide = {{WORD_WIDTH{1'b0}}, number};
  assign num_w    = num_wide[WORD_WIDTH-1:0];

  always_comb begin
    priority if (radix < RADIX_MIN) begin
      radix_sat = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_sat = RADIX_MAX;
    end else begin
      radix_sat = radix;
    end
  end

  assign neg_in = signed_mode && (radix_sat == RADIX_DEC) && num_w[WORD_WIDTH-1];

  // One restoring step: shift in the next dividend bit, subtract when it fits.
  assign rem_sh  = {rem, val[WORD_WIDTH-1]};
  assign q_bit   = (rem_sh >= {1'b0, radix_r});
  assign rem_new = q_bit ? DIGIT_W'(rem_sh - {1'b0, radix_r}) : rem_sh[DIGIT_W-1:0];
  assign quo_new = {val[WORD_WIDTH-2:0], q_bit};

  assign step_last = (step == SW'(WORD_WIDTH - 1));
  assign digit_we  = cmd.step && step_last;
  assign count_dec = count - CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      val     <= neg_in ? (~num_w + WORD_WIDTH'(1)) : num_w;
      radix_r <= radix_sat;
      neg     <= neg_in;
      rem     <= '0;
      step    <= '0;
      count   <= '0;
    end else if (cmd.step) begin
      val <= quo_new;
      if (step_last) begin
        rem   <= '0;
        step  <= '0;
        count <= count + CW'(1);
      end else begin
        rem  <= rem_new;
        step <= step + SW'(1);
      end
    end else if (cmd.read) begin
      count <= count_dec;
    end
    if (cmd.sign_load) begin
      ascii_char <= CHAR_MINUS;
      last_char  <= 1'b0;
    end else if (cmd.char_load) begin
      ascii_char <= digit_to_char(rd_digit);
      last_char  <= (count == '0);
    end
  end

  // Digits come out least significant first; the stack hands them back in reverse.
  i2a_ram #(
    .WIDTH (DIGIT_W),
    .DEPTH (WORD_WIDTH)
  ) u_digits (
    .clk   (clk),
    .we    (digit_we),
    .waddr (count[AW-1:0]),
    .wdata (rem_new),
    .re    (cmd.read),
    .raddr (count_dec[AW-1:0]),
    .rdata (rd_digit)
  );

  assign status.neg           = neg;
  assign status.step_last     = step_last;
  assign status.quo_zero_next = (quo_new == '0);
  assign status.count_zero    = (count == '0);

endmodule

// ===== design/i2a_ctrl.sv =====
// Controller: sequences load, division, sign and digit output for one number.
module i2a_ctrl import i2a_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  i2a_status_t status,
  output i2a_cmd_t    cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_SIGN = 6'b000100,
    S_RD   = 6'b001000,
    S_LD   = 6'b010000,
    S_SHOW = 6'b100000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        cmd.step = 1'b1;
        if (status.step_last && status.quo_zero_next) begin
          state_next = status.neg ? S_SIGN : S_RD;
        end
      end
      S_SIGN: begin
        cmd.sign_load = 1'b1;
        state_next    = S_SHOW;
      end
      S_RD: begin
        cmd.read   = 1'b1;
        state_next = S_LD;
      end
      S_LD: begin
        cmd.char_load = 1'b1;
        state_next    = S_SHOW;
      end
      S_SHOW: begin
        if (out_ready) begin
          state_next = status.count_zero ? S_IDLE : S_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_SHOW);

endmodule

// ===== design/i2a_checker.sv =====
// Port-level checker for the radix converter and its bind to the top level.
module i2a_checker import i2a_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] ascii_char,
  input logic              last_char
);

  // One number at a time: never take input while a character is offered.
  a_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("in_ready and out_valid high together");

  // Reset leaves the block idle and ready.
  a_reset: assert property (@(posedge clk)
    rst |=> (in_ready && !out_valid))
    else $error("block not idle after reset");

  // An accepted number keeps the input closed in the next cycle.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input reopened right after a transaction");

  // Only legal characters are offered.
  a_charset: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((ascii_char == CHAR_MINUS)
                   || (ascii_char >= CHAR_ZERO && ascii_char <= CHAR_NINE)
                   || (ascii_char >= CHAR_LOWER_A && ascii_char <= CHAR_LOWER_Z)))
    else $error("illegal character offered");

  // A stalled character holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(ascii_char) && $stable(last_char)))
    else $error("stalled character changed");

endmodule

bind integer_to_ascii_radix i2a_checker u_i2a_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .ascii_char (ascii_char),
  .last_char  (last_char)
);
